// File: rtl/hml_pkg.sv
// Shared types, constants and the Morse element table for the hex Morse LED keyer.
// No dependencies; imported by hml_encoder, hex_morse_led_keyer, morse_led_sb_pkg and the testbench.

package hml_pkg;

  localparam int unsigned VALUE_W   = 16;  // four hex digits
  localparam int unsigned DIGITS    = 4;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned ELEM_W    = 20; // at most five elements per digit
  localparam int unsigned LEFT_W    = 5;  // holds 0..ELEM_W
  localparam int unsigned ELEN_W    = 3;  // length of one digit, 1..5
  localparam int unsigned PAT_W     = 5;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TICK_W-1:0] UNIT_TICKS    = 16'd200;
  localparam logic [TICK_W-1:0] DOT_RESET     = UNIT_TICKS;
  localparam logic [TICK_W-1:0] DASH_RESET    = 16'(3 * UNIT_TICKS);
  localparam logic [TICK_W-1:0] CHAR_RESET    = 16'(3 * UNIT_TICKS);
  localparam logic [TICK_W-1:0] WORD_RESET    = 16'(UNIT_TICKS * 7);

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT      = 3'd0,
    REG_DASH     = 3'd1,
    REG_CHAR_GAP = 3'd2,
    REG_WORD_GAP = 3'd3
  } cfg_reg_e;

  // Keyer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LIT  = 4'b0010,
    PH_GAP  = 4'b0100,
    PH_WORD = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [PAT_W-1:0]  bits; // 1 = dash, sent from top bit down
    logic [ELEN_W-1:0] len;
  } morse_entry_t;

  // Encoded message handed from the encoder to the keyer
  typedef struct packed {
    logic [ELEM_W-1:0] bits;
    logic [ELEM_W-1:0] marks;
    logic [LEFT_W-1:0] len;
  } code_t;

  function automatic morse_entry_t morse_lookup(input logic [DIGIT_W-1:0] digit);
    morse_entry_t e;
    case (digit)
      4'h0:    e = '{bits: 5'h1F, len: 3'd5};
      4'h1:    e = '{bits: 5'h0F, len: 3'd5};
      4'h2:    e = '{bits: 5'h07, len: 3'd5};
      4'h3:    e = '{bits: 5'h03, len: 3'd5};
      4'h4:    e = '{bits: 5'h01, len: 3'd5};
      4'h5:    e = '{bits: 5'h00, len: 3'd5};
      4'h6:    e = '{bits: 5'h10, len: 3'd5};
      4'h7:    e = '{bits: 5'h18, len: 3'd5};
      4'h8:    e = '{bits: 5'h1C, len: 3'd5};
      4'h9:    e = '{bits: 5'h1E, len: 3'd5};
      4'hA:    e = '{bits: 5'h01, len: 3'd2};
      4'hB:    e = '{bits: 5'h08, len: 3'd4};
      4'hC:    e = '{bits: 5'h0A, len: 3'd4};
      4'hD:    e = '{bits: 5'h04, len: 3'd3};
      4'hE:    e = '{bits: 5'h00, len: 3'd1};
      default: e = '{bits: 5'h02, len: 3'd4};
    endcase
    return e;
  endfunction

endpackage

// File: rtl/hml_encoder.sv
// Packs the four hex digits of a value into one element string with character-end marks.
// Depends on hml_pkg (table and code_t).

module hml_encoder (
  input  logic [hml_pkg::VALUE_W-1:0] value_i,
  output hml_pkg::code_t              code_o
);
  import hml_pkg::*;

  morse_entry_t      e;
  logic [LEFT_W-1:0] pos;
  logic [ELEM_W-1:0] bits;
  logic [ELEM_W-1:0] marks;

  // Least significant digit lands at the bottom, so the top digit goes out first
  always_comb begin
    pos   = '0;
    bits  = '0;
    marks = '0;
    e     = '0;
    for (int d = 0; d < DIGITS; d++) begin
      e = morse_lookup(value_i[DIGIT_W*d +: DIGIT_W]);
      if (d > 0) begin
        marks = marks | (ELEM_W'(1) << pos);
      end
      bits = bits | (ELEM_W'(e.bits) << pos);
      pos  = pos + LEFT_W'(e.len);
    end
  end

  assign code_o.bits  = bits;
  assign code_o.marks = marks;
  assign code_o.len   = pos;

endmodule

// File: rtl/hex_morse_led_keyer.sv
// Top level of the hex Morse LED keyer: input register, keyer state, result register.
// Depends on hml_pkg and hml_encoder.
//
// Usage
//   Input channel (in_valid_i / in_stall_o): each transfer carries mode_i and value_i.
//   mode_i = 0 is one timer tick, mode_i = 1 loads value_i, whose four hex digits are
//   sent as Morse code, top digit first. Every input transfer yields exactly one
//   result transfer on the output channel (out_valid_o / out_stall_i) carrying the
//   LED level, busy, a done pulse at the end of the word gap, and a refusal flag
//   for a load that arrives while a message is still going out.
//   Timing registers are written through cfg_we_i / cfg_idx_i / cfg_data_i:
//   0 dot, 1 dash, 2 character gap, 3 word gap, in ticks; zero counts as one,
//   other indices are ignored. Write them only while no item is in flight.
// Pipeline and throughput
//   An input transfer goes into the input register, then through the encoder /
//   phase logic into the result register. One item per cycle sustained while
//   out_stall_i does not hold a full result register.
// Reset
//   rst_ni clears both pipeline valids and the keyer to idle, and restores the
//   timing registers to 200 / 600 / 600 / 1400 ticks.
// Back-pressure
//   While out_stall_i holds a full result register, the item in the input
//   register waits and in_stall_o rises; nothing is lost or repeated.

module hex_morse_led_keyer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [hml_pkg::VALUE_W-1:0]   value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          led_on_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          load_refused_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [hml_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hml_pkg::TICK_W-1:0]    cfg_data_i
);
  import hml_pkg::*;

  // Timing registers
  logic [TICK_W-1:0] dot_q, dash_q, char_q, word_q;

  // Input register
  logic               s1_valid_q;
  logic               s1_mode_q;
  logic [VALUE_W-1:0] s1_value_q;

  // Keyer state
  logic [ELEM_W-1:0] code_bits_q,  code_bits_d;
  logic [ELEM_W-1:0] marks_q,      marks_d;
  logic [LEFT_W-1:0] left_q,       left_d;
  phase_e            phase_q,      phase_d;
  logic [TICK_W-1:0] tick_q,       tick_d;

  // Result register
  logic out_valid_q;
  logic led_q, busy_q, done_q, refused_q;
  logic done_d, refused_d;

  logic              out_free;
  logic              s1_fire;
  code_t             enc;
  logic [LEFT_W-1:0] cur_pos;
  logic [LEFT_W-1:0] left_dec;
  logic              cur_ok;
  logic              cur_code;
  logic              cur_mark;
  logic [TICK_W-1:0] len_sel;
  logic [TICK_W-1:0] len_eff;
  logic [TICK_W-1:0] tick_inc;
  logic              cnt_done;

  // Result register drains or is empty: the input stage may advance
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  hml_encoder u_enc (
    .value_i (s1_value_q),
    .code_o  (enc)
  );

  // Element currently being sent sits at bit left-1
  assign cur_pos  = left_q - LEFT_W'(1);
  assign cur_ok   = (left_q != '0) && (cur_pos < LEFT_W'(ELEM_W));
  assign cur_code = cur_ok && code_bits_q[cur_pos];
  assign cur_mark = cur_ok && marks_q[cur_pos];
  assign left_dec = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;

  always_comb begin
    case (phase_q)
      PH_LIT:  len_sel = cur_code ? dash_q : dot_q;
      PH_GAP:  len_sel = cur_mark ? char_q : dot_q;
      PH_WORD: len_sel = word_q;
      default: len_sel = dot_q;
    endcase
  end

  // A zero length still lasts one tick; the counter wraps at 16 bits
  assign len_eff  = (len_sel == '0) ? TICK_W'(1) : len_sel;
  assign tick_inc = tick_q + TICK_W'(1);
  assign cnt_done = tick_inc >= len_eff;

  always_comb begin
    code_bits_d = code_bits_q;
    marks_d     = marks_q;
    left_d      = left_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    done_d      = 1'b0;
    refused_d   = 1'b0;
    if (s1_mode_q) begin
      // load: refuse while busy, otherwise start the first element at once
      if (phase_q != PH_IDLE) begin
        refused_d = 1'b1;
      end else begin
        code_bits_d = enc.bits;
        marks_d     = enc.marks;
        left_d      = enc.len;
        phase_d     = PH_LIT;
        tick_d      = '0;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        PH_LIT: begin
          tick_d = tick_inc;
          if (cnt_done) begin
            phase_d = PH_GAP;
            tick_d  = '0;
          end
        end
        PH_GAP: begin
          tick_d = tick_inc;
          if (cnt_done) begin
            tick_d  = '0;
            left_d  = left_dec;
            phase_d = (left_dec != '0) ? PH_LIT : PH_WORD;
          end
        end
        PH_WORD: begin
          tick_d = tick_inc;
          if (cnt_done) begin
            tick_d  = '0;
            phase_d = PH_IDLE;
            done_d  = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      endcase
    end
  end

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= DOT_RESET;
      dash_q <= DASH_RESET;
      char_q <= CHAR_RESET;
      word_q <= WORD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DOT:      dot_q  <= cfg_data_i;
        REG_DASH:     dash_q <= cfg_data_i;
        REG_CHAR_GAP: char_q <= cfg_data_i;
        REG_WORD_GAP: word_q <= cfg_data_i;
        default:      ; // drop writes beyond the register list
      endcase
    end
  end

  // Input register: take a new transfer whenever not held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_mode_q  <= mode_i;
      s1_value_q <= value_i;
    end
  end

  // Keyer state: advance only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= '0;
      marks_q     <= '0;
      left_q      <= '0;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
    end else if (s1_fire) begin
      code_bits_q <= code_bits_d;
      marks_q     <= marks_d;
      left_q      <= left_d;
      phase_q     <= phase_d;
      tick_q      <= tick_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      led_q     <= (phase_d == PH_LIT);
      busy_q    <= (phase_d != PH_IDLE);
      done_q    <= done_d;
      refused_q <= refused_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_on_o       = led_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign load_refused_o = refused_q;

  // A finished word gap leaves the keyer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !led_on_o)
    else $error("done pulse while still busy");

  // A refused load only happens while a message is in progress
  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && load_refused_o |-> busy_res_o && !done_res_o)
    else $error("load refused while idle");

  // The element count never exceeds the longest message
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= LEFT_W'(ELEM_W))
    else $error("element count out of range");

  // A held input item leaves the keyer state untouched
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(phase_q) && $stable(tick_q))
    else $error("keyer state moved while stalled");

endmodule

// File: sim/morse_led_sb_pkg.sv
// Scoreboard for the hex Morse LED keyer: a predictor of the keyer phase
// and message state, and a queue of the LED / busy / done / refusal levels due.
// Depends on hml_pkg for widths, reset lengths and the phase and register enums.

package morse_led_sb_pkg;
  import hml_pkg::*;

  // Element patterns (1 = dash, top bit first) of digits F..0, digit 0 in slot 0
  localparam logic [15:0][4:0] DIGIT_PATTERN = {
    5'h02, 5'h00, 5'h04, 5'h0A, 5'h08, 5'h01, 5'h1E, 5'h1C,
    5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F, 5'h1F
  };
  localparam logic [15:0][2:0] DIGIT_LENGTH = {
    3'd4, 3'd1, 3'd3, 3'd4, 3'd4, 3'd2, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  typedef struct packed {
    logic led;
    logic busy;
    logic done;
    logic refused;
  } led_levels_t;

  class morse_led_scoreboard;
    logic [TICK_W-1:0] dot_len;
    logic [TICK_W-1:0] dash_len;
    logic [TICK_W-1:0] char_gap_len;
    logic [TICK_W-1:0] word_gap_len;
    logic [ELEM_W-1:0] dash_bits;
    logic [ELEM_W-1:0] char_ends;
    logic [LEFT_W-1:0] elems_left;
    phase_e            phase;
    logic [TICK_W-1:0] tick_count;
    led_levels_t       levels_due[$];
    int unsigned       errors;

    function new();
      dot_len      = DOT_RESET;
      dash_len     = DASH_RESET;
      char_gap_len = CHAR_RESET;
      word_gap_len = WORD_RESET;
      dash_bits    = '0;
      char_ends    = '0;
      elems_left   = '0;
      phase        = PH_IDLE;
      tick_count   = '0;
      errors       = 0;
    endfunction

    function void set_timing(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
      case (idx)
        REG_DOT:      dot_len = data;
        REG_DASH:     dash_len = data;
        REG_CHAR_GAP: char_gap_len = data;
        REG_WORD_GAP: word_gap_len = data;
        default: ;
      endcase
    endfunction

    function bit keyer_idle();
      return phase == PH_IDLE;
    endfunction

    function int unsigned pending();
      return levels_due.size();
    endfunction

    // Bit of the element now being sent
    function logic element_bit(logic [ELEM_W-1:0] word);
      if (elems_left == '0 || elems_left > ELEM_W) return 1'b0;
      return word[elems_left - 5'd1];
    endfunction

    // Count one tick; a zero length lasts one tick
    function bit phase_elapsed(logic [TICK_W-1:0] len);
      tick_count = tick_count + 1'b1;
      if (len == '0) return tick_count != '0;
      return tick_count >= len;
    endfunction

    function void load_message(logic [VALUE_W-1:0] value);
      int unsigned pos;
      int unsigned d;
      logic [31:0] bits;
      logic [31:0] marks;
      logic [DIGIT_W-1:0] digit;
      pos   = 0;
      bits  = '0;
      marks = '0;
      for (d = 0; d < DIGITS; d++) begin
        digit = value[DIGIT_W*d +: DIGIT_W];
        if (d > 0) marks[pos] = 1'b1;
        bits = bits | (32'(DIGIT_PATTERN[digit]) << pos);
        pos += DIGIT_LENGTH[digit];
      end
      dash_bits  = bits[ELEM_W-1:0];
      char_ends  = marks[ELEM_W-1:0];
      elems_left = pos[LEFT_W-1:0];
    endfunction

    // Advance the keyer by one item and queue its levels; 0 when it was ignored
    function bit note_item(logic mode, logic [VALUE_W-1:0] value);
      led_levels_t want;
      bit moved;
      want  = '0;
      moved = 1'b1;
      if (mode) begin
        if (phase != PH_IDLE) begin
          want.refused = 1'b1;
          moved = 1'b0;
        end else begin
          load_message(value);
          phase = PH_LIT;
          tick_count = '0;
        end
      end else begin
        case (phase)
          PH_LIT: begin
            if (phase_elapsed(element_bit(dash_bits) ? dash_len : dot_len)) begin
              phase = PH_GAP;
              tick_count = '0;
            end
          end
          PH_GAP: begin
            if (phase_elapsed(element_bit(char_ends) ? char_gap_len : dot_len)) begin
              tick_count = '0;
              if (elems_left != '0) elems_left--;
              phase = (elems_left != '0) ? PH_LIT : PH_WORD;
            end
          end
          PH_WORD: begin
            if (phase_elapsed(word_gap_len)) begin
              tick_count = '0;
              phase = PH_IDLE;
              want.done = 1'b1;
            end
          end
          default: moved = 1'b0;
        endcase
      end
      want.led  = (phase == PH_LIT);
      want.busy = (phase != PH_IDLE);
      levels_due.push_back(want);
      return moved;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic got, logic want);
      if (got !== want) report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    task check_result(logic led, logic busy, logic done, logic refused);
      led_levels_t want;
      if (levels_due.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      want = levels_due.pop_front();
      compare_field("led_on", led, want.led);
      compare_field("busy_res", busy, want.busy);
      compare_field("done_res", done, want.done);
      compare_field("load_refused", refused, want.refused);
    endtask
  endclass

endpackage

// File: sim/tb_hex_morse_led_keyer.sv
// Self-checking testbench for hex_morse_led_keyer: directed and random tick / load
// transfers under random idling and receiver stalls, every result checked against a predictor.
// Depends on hml_pkg, morse_led_sb_pkg and the keyer RTL.

module tb_hex_morse_led_keyer;
  timeunit 1ns;
  timeprecision 1ps;

  import hml_pkg::*;
  import morse_led_sb_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 600;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned TAIL_CYCLES     = 8;   // two-stage pipe plus margin
  localparam int unsigned FIRST_SPARE_IDX = REG_WORD_GAP + 1;
  localparam int unsigned LAST_SPARE_IDX  = (1 << CFG_IDX_W) - 1;
  localparam logic        MODE_TICK       = 1'b0;
  localparam logic        MODE_LOAD       = 1'b1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 mode_i      = MODE_TICK;
  logic [VALUE_W-1:0]   value_i     = '0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [TICK_W-1:0]    cfg_data_i  = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 led_on_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic                 load_refused_o;

  morse_led_scoreboard sb;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         quiet_cycles   = 0;
  int unsigned         moved_items    = 0;

  hex_morse_led_keyer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_on_o       (led_on_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .load_refused_o (load_refused_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Receiver: stall at random, at the rate the current phase sets
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check every result transfer and keep the watchdog on any transfer at all.
  // Values read here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(led_on_o, busy_res_o, done_res_o, load_refused_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item, idling first at the phase's rate; hold the payload until the
  // transfer, then advance the predictor. Valid stays high into the next item.
  task automatic send_item(input logic mode, input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.note_item(mode, value)) moved_items++;
  endtask

  // Drop valid and hold until every expected result has come, then let the pipe settle.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_timing(idx, data);
  endtask

  // Reprogram all four lengths once the pipe is empty; a write to a spare index
  // goes along each time and must change nothing.
  task automatic program_timing(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                                input logic [TICK_W-1:0] char_gap,
                                input logic [TICK_W-1:0] word_gap);
    logic [CFG_IDX_W-1:0] spare_idx;
    spare_idx = CFG_IDX_W'($urandom_range(LAST_SPARE_IDX, FIRST_SPARE_IDX));
    wait_for_results();
    write_timing(spare_idx, TICK_W'($urandom_range(16'hFFFF)));
    write_timing(REG_DOT, dot);
    write_timing(REG_DASH, dash);
    write_timing(REG_CHAR_GAP, char_gap);
    write_timing(REG_WORD_GAP, word_gap);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly short lengths so that many messages complete; zero now and then
  function automatic logic [TICK_W-1:0] pick_length();
    if ($urandom_range(7) == 0) return '0;
    return TICK_W'($urandom_range(($urandom_range(3) == 0) ? 9 : 3, 1));
  endfunction

  initial begin
    int unsigned ph;
    int unsigned target;
    logic        mode;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a tick while idle does nothing, whatever the value
    send_item(MODE_TICK, 16'hFFFF);

    // Zero dot length counts as one; four single-dot characters then the word gap
    program_timing(16'd0, 16'd1, 16'd1, 16'd1);
    send_item(MODE_LOAD, 16'hEEEE);
    send_item(MODE_LOAD, 16'h0000);              // refused, keyer busy
    repeat (9) send_item(MODE_TICK, VALUE_W'($urandom_range(16'hFFFF)));
    send_item(MODE_TICK, 16'h0000);              // idle again after done

    // Longest lengths, then cut the dash below the count already reached:
    // the lit phase must end on the very next tick
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(MODE_LOAD, 16'h0000);              // twenty dashes
    repeat (3) send_item(MODE_TICK, VALUE_W'($urandom_range(16'hFFFF)));
    program_timing(16'd1, 16'd2, 16'd0, 16'd2);
    repeat (4) send_item(MODE_TICK, VALUE_W'($urandom_range(16'hFFFF)));

    // Random: mostly ticks while busy, mostly loads while idle, refused loads as noise
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_timing(pick_length(), pick_length(), pick_length(), pick_length());
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      target = moved_items + RANDOM_ITEMS / RANDOM_PHASES;
      while (moved_items < target) begin
        // Pause now and then until the pipe is empty
        if ($urandom_range(63) == 0) wait_for_results();
        if (sb.keyer_idle()) mode = ($urandom_range(9) != 0);
        else mode = ($urandom_range(15) == 0);
        send_item(mode, VALUE_W'($urandom_range(16'hFFFF)));
      end
    end

    wait_for_results();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hml_pkg.sv
rtl/hml_encoder.sv
rtl/hex_morse_led_keyer.sv
sim/morse_led_sb_pkg.sv
sim/tb_hex_morse_led_keyer.sv
